>>> design/fvu_pkg.sv
// Package: FNV-1a-64 constants, identifier stamps and controller command type.
package fvu_pkg;

   localparam logic [63:0] FNV_PRIME   = 64'h0000_0100_0000_01b3;
   localparam logic [63:0] FIRST_BASE  = 64'hcbf2_9ce4_8422_2325;
   localparam logic [63:0] SECOND_BASE = 64'h8422_2325_cbf2_9ce4;

   localparam logic [3:0] VERSION_NIBBLE = 4'h4;
   localparam logic [1:0] VARIANT_BITS   = 2'b10;

   localparam int unsigned REMIX_STEPS = 8;
   localparam int unsigned IDX_W       = $clog2(REMIX_STEPS);

   typedef struct packed {
      logic             absorb;
      logic             remix;
      logic [IDX_W-1:0] remix_idx;
      logic             load;
   } fvu_cmd_type;

   // h * 0x100000001b3 mod 2^64 as shift-adds (2^40 + 0x1b3)
   function automatic logic [63:0] fnv_mul(input logic [63:0] h);
      return (h << 40) + (h << 8) + (h << 7) + (h << 5) + (h << 4) + (h << 1) + h;
   endfunction

   function automatic logic [63:0] fnv_absorb(input logic [63:0] h, input logic [7:0] b);
      return fnv_mul(h ^ {56'd0, b});
   endfunction

endpackage

>>> design/fvu_if.sv
// Channel interfaces: seed byte request and identifier response.
interface fvu_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] seed_byte;
   logic       last;

   modport source (output valid, output seed_byte, output last, input ready);
   modport sink   (input valid, input seed_byte, input last, output ready);
endinterface

interface fvu_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] uuid_high;
   logic [63:0] uuid_low;

   modport source (output valid, output uuid_high, output uuid_low, input ready);
   modport sink   (input valid, input uuid_high, input uuid_low, output ready);
endinterface

>>> design/fvu_datapath.sv
// Datapath: the two hash registers, remix step and stamped output register.
module fvu_datapath
   import fvu_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  fvu_cmd_type cmd,
   input  logic [7:0]  seed_byte,
   output logic [63:0] uuid_high,
   output logic [63:0] uuid_low
);

   logic [63:0] first_ff, first_in;
   logic [63:0] second_ff, second_in;
   logic [63:0] high_ff, high_in;
   logic [63:0] low_ff, low_in;
   logic [7:0]  remix_byte;

   assign remix_byte = first_ff[{cmd.remix_idx, 3'b000} +: 8];

   always_comb begin
      first_in  = first_ff;
      second_in = second_ff;
      high_in   = high_ff;
      low_in    = low_ff;
      if (cmd.absorb) begin
         first_in  = fnv_absorb(first_ff, seed_byte);
         second_in = fnv_absorb(second_ff, seed_byte);
      end else if (cmd.remix) begin
         second_in = fnv_absorb(second_ff, remix_byte);
      end else if (cmd.load) begin
         high_in   = {first_ff[63:16], VERSION_NIBBLE, first_ff[11:0]};
         low_in    = {VARIANT_BITS, second_ff[61:0]};
         first_in  = FIRST_BASE;
         second_in = SECOND_BASE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_ff  <= FIRST_BASE;
         second_ff <= SECOND_BASE;
      end else begin
         first_ff  <= first_in;
         second_ff <= second_in;
      end
      high_ff <= high_in;
      low_ff  <= low_in;
   end

   assign uuid_high = high_ff;
   assign uuid_low  = low_ff;

endmodule

>>> design/fvu_ctrl.sv
// Controller: accepts bytes, sequences the eight-step remix, drives response valid.
module fvu_ctrl
   import fvu_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_last,
   output logic        req_ready,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output fvu_cmd_type cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_REMIX,
      ST_DONE
   } state_type;

   state_type        state_ff, state_in;
   logic [IDX_W-1:0] cnt_ff, cnt_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             req_take;
   logic             load;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_take  = req_valid && req_ready;
   assign load      = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            cnt_in = '0;
            if (req_take && req_last) state_in = ST_REMIX;
         end
         ST_REMIX: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == IDX_W'(REMIX_STEPS - 1)) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (load) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign cmd.absorb    = req_take;
   assign cmd.remix     = (state_ff == ST_REMIX);
   assign cmd.remix_idx = cnt_ff;
   assign cmd.load      = load;

endmodule

>>> design/fnv1a64_dual_uuid_derive.sv
// Top level: dual FNV-1a-64 seed hash deriving a version 4 style 128-bit identifier.
// A byte that is not last is absorbed when accepted; the next one is accepted in the following cycle.
// A last byte holds off the next transaction for: absorb, eight remix steps of
// the second hash over the first hash's bytes, then the load of the output register.
// The response appears the cycle after the load and may wait while new bytes arrive.
// Synchronous reset returns both hashes to their offset bases and clears response valid.
module fnv1a64_dual_uuid_derive
   import fvu_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   fvu_req_if.sink  req_chan,
   fvu_rsp_if.source rsp_chan
);

   fvu_cmd_type cmd;

   fvu_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_last  (req_chan.last),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .cmd       (cmd)
   );

   fvu_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .seed_byte (req_chan.seed_byte),
      .uuid_high (rsp_chan.uuid_high),
      .uuid_low  (rsp_chan.uuid_low)
   );

endmodule
